>>> sv/uvgh_pkg.sv
// Shared constants, types and helper functions for the uv grid histogram descriptor.
// Used by the top level, the binner and the subtract unit; no dependencies of its own.
package uvgh_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int COUNT_BITS = 16;

  // Field and register widths fixed by the interface.
  localparam int CFG_W    = 7;
  localparam int COORD_W  = 16;
  localparam int BIN_W    = 6;
  localparam int FUNC_W   = 2;
  localparam int OUT_W    = 16;
  localparam int CIDX_W   = 2;

  localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int SIZE_LOG = $clog2(MAX_DIM + 1);
  localparam int SIZE_W   = (SIZE_LOG > CFG_W) ? SIZE_LOG : CFG_W;
  localparam int IDX_W    = (SIZE_W + 1 > BIN_W) ? SIZE_W + 1 : BIN_W;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_LOG = $clog2(DEPTH);
  localparam int ADDR_W   = (ADDR_LOG > 1) ? ADDR_LOG : 1;

  // Divide of count * 2^32 by the total, then square root of the quotient.
  localparam int QW      = COUNT_BITS + 32;
  localparam int SQ      = QW / 2;
  localparam int ALU_W   = (COUNT_BITS + 1 > SQ + 3) ? COUNT_BITS + 1 : SQ + 3;
  localparam int STEP_W  = $clog2(QW);

  localparam logic [17:0] HALF_Q15 = 18'd16384;
  localparam logic [17:0] ONE_Q15  = 18'd32768;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_GRID_COLS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FLIP_U    = 2'd2;
  localparam logic [CIDX_W-1:0] REG_FLIP_V    = 2'd3;

  // Bin lookup result handed from the binner to the sequencer.
  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] addr;
  } bin_addr_t;

  // Result of the shared subtract and compare unit.
  typedef struct packed {
    logic             ge;
    logic [ALU_W-1:0] diff;
  } alu_res_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r,
                                                 input int unsigned maxv);
    logic [SIZE_W-1:0] rv;
    logic [SIZE_W-1:0] mv;
    rv = SIZE_W'(r);
    mv = SIZE_W'(maxv);
    if (rv == '0) begin
      return SIZE_W'(1);
    end else if (rv > mv) begin
      return mv;
    end
    return rv;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == '1) ? c : c + COUNT_BITS'(1);
  endfunction

  function automatic logic [OUT_W-1:0] sat16_cnt(input logic [COUNT_BITS-1:0] c);
    return (64'(c) > 64'd65535) ? '1 : OUT_W'(c);
  endfunction

  function automatic logic [OUT_W-1:0] sat16_root(input logic [SQ-1:0] r);
    return (64'(r) > 64'd65535) ? '1 : OUT_W'(r);
  endfunction

endpackage

>>> sv/uv_grid_histogram_descriptor_top.sv
// Top level of the uv grid histogram descriptor: sequencer, grid store and result register.
// Depends on uvgh_pkg, uvgh_ram, uvgh_binner and uvgh_alu.
//
//   Channel  Direction  Signals                              Content
//   s_*      in         s_tvalid s_tready s_tdata s_tuser    one request item
//   m_*      out        m_tvalid m_tready m_tdata            one result item per request
//   cfg_*    in         cfg_we cfg_index cfg_data            register writes
//
// An add passes through decode, store read, read-modify-write and result.
// A read also divides and takes a root: the shared subtractor runs one restoring divide
// step per cycle for count * 2^32 / total, then one square root digit per cycle.
// A clear sweeps the 4096-entry store one entry per cycle;
// the same sweep runs after reset, and no item is taken until it ends.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register while the next item is taken, and stalls the sequencer only if it is
// still not taken when the following result is ready.
module uv_grid_histogram_descriptor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [15:0] point_u, [31:16] point_v, [37:32] bin_col, [43:38] bin_row, [47:44] zero
  input  logic [47:0] s_tdata,
  // [1:0] func
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] point_binned, [16:1] bin_count, [32:17] bin_value, [48:33] total_points,
  // [55:49] zero
  output logic [55:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import uvgh_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_DATA   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_SQRT   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  // Configuration registers.
  logic [CFG_W-1:0] grid_cols;
  logic [CFG_W-1:0] grid_rows;
  logic             flip_u;
  logic             flip_v;

  // Sequencer state.
  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_reply;
  logic [STEP_W-1:0] step;

  // Latched request.
  logic [FUNC_W-1:0]  it_func;
  logic [COORD_W-1:0] it_u;
  logic [COORD_W-1:0] it_v;
  logic [BIN_W-1:0]   it_col;
  logic [BIN_W-1:0]   it_row;

  // Working registers.
  logic [ADDR_W-1:0]     addr;
  logic [COUNT_BITS-1:0] total;
  logic [QW-1:0]         quo;
  logic [ALU_W-1:0]      rem;
  logic [SQ-1:0]         root;
  logic [SQ-1:0]         root_next;

  // Finished result and output register.
  logic             res_binned;
  logic [OUT_W-1:0] res_cnt;
  logic [OUT_W-1:0] res_val;
  logic             out_binned;
  logic [OUT_W-1:0] out_cnt;
  logic [OUT_W-1:0] out_val;
  logic [OUT_W-1:0] out_total;
  logic             out_valid_q;
  logic             slot_free;

  // Grid store ports.
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  bin_addr_t bin;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  alu_res_t         alu;

  uvgh_binner u_binner (
    .is_read   (it_func == FUNC_READ),
    .point_u   (it_u),
    .point_v   (it_v),
    .bin_col   (it_col),
    .bin_row   (it_row),
    .grid_cols (grid_cols),
    .grid_rows (grid_rows),
    .flip_u    (flip_u),
    .flip_v    (flip_v),
    .bin       (bin)
  );

  uvgh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  uvgh_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid_q;
  assign slot_free = !out_valid_q || m_tready;
  assign m_tdata   = {7'd0, out_total, out_val, out_cnt, out_binned};

  // The store is written by the clearing sweep and by the increment of an added point.
  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_DATA && it_func == FUNC_ADD);
    ram_waddr = (state == S_CLEAR) ? clr_addr : addr;
    ram_wdata = (state == S_CLEAR) ? '0 : sat_inc(ram_rdata);
  end

  // The subtractor serves a restoring divide step (remainder with the next dividend bit
  // shifted in, against the total) or a root digit (remainder with the next two bits,
  // against the root with 01 appended).
  always_comb begin
    if (state == S_SQRT) begin
      alu_a = {rem[ALU_W-3:0], quo[QW-1:QW-2]};
      alu_b = ALU_W'({root, 2'b01});
    end else begin
      alu_a = ALU_W'({rem[COUNT_BITS-1:0], quo[QW-1]});
      alu_b = ALU_W'(total);
    end
    root_next = {root[SQ-2:0], alu.ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= CFG_W'(48);
      grid_rows <= CFG_W'(48);
      flip_u    <= 1'b0;
      flip_v    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_COLS: grid_cols <= cfg_data;
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_FLIP_U:    flip_u    <= cfg_data[0];
        REG_FLIP_V:    flip_v    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_reply   <= 1'b0;
      total       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // A new result may enter the output register in the same cycle as the old one leaves.
      if (state == S_FIN && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_reply ? S_FIN : S_IDLE;
          end else begin
            clr_addr <= clr_addr + ADDR_W'(1);
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            it_func <= s_tuser;
            it_u    <= s_tdata[15:0];
            it_v    <= s_tdata[31:16];
            it_col  <= s_tdata[37:32];
            it_row  <= s_tdata[43:38];
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_binned <= 1'b0;
          res_cnt    <= '0;
          res_val    <= '0;
          addr       <= bin.addr;
          unique case (it_func)
            FUNC_ADD, FUNC_READ: state <= bin.hit ? S_READ : S_FIN;
            FUNC_CLEAR: begin
              total     <= '0;
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end
            FUNC_NOP: state <= S_FIN;
            default:  state <= S_FIN;
          endcase
        end
        S_READ: begin
          state <= S_DATA;
        end
        S_DATA: begin
          if (it_func == FUNC_ADD) begin
            total      <= sat_inc(total);
            res_binned <= 1'b1;
            state      <= S_FIN;
          end else begin
            res_cnt <= sat16_cnt(ram_rdata);
            quo     <= {ram_rdata, 32'd0};
            rem     <= '0;
            step    <= STEP_W'(QW - 1);
            state   <= (total == '0) ? S_FIN : S_DIV;
          end
        end
        S_DIV: begin
          quo <= {quo[QW-2:0], alu.ge};
          if (step == '0) begin
            rem   <= '0;
            root  <= '0;
            step  <= STEP_W'(SQ - 1);
            state <= S_SQRT;
          end else begin
            rem  <= alu.ge ? alu.diff : alu_a;
            step <= step - STEP_W'(1);
          end
        end
        S_SQRT: begin
          rem  <= alu.ge ? alu.diff : alu_a;
          quo  <= {quo[QW-3:0], 2'b00};
          root <= root_next;
          step <= step - STEP_W'(1);
          if (step == '0) begin
            res_val <= sat16_root(root_next);
            state   <= S_FIN;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_binned <= res_binned;
            out_cnt    <= res_cnt;
            out_val    <= res_val;
            out_total  <= sat16_cnt(total);
            clr_reply  <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/uvgh_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module uvgh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/uvgh_binner.sv
// Maps an added point, or a requested read position, to a grid store address.
// Depends on uvgh_pkg.
module uvgh_binner (
  input  logic                          is_read,
  input  logic [uvgh_pkg::COORD_W-1:0]  point_u,
  input  logic [uvgh_pkg::COORD_W-1:0]  point_v,
  input  logic [uvgh_pkg::BIN_W-1:0]    bin_col,
  input  logic [uvgh_pkg::BIN_W-1:0]    bin_row,
  input  logic [uvgh_pkg::CFG_W-1:0]    grid_cols,
  input  logic [uvgh_pkg::CFG_W-1:0]    grid_rows,
  input  logic                          flip_u,
  input  logic                          flip_v,
  output uvgh_pkg::bin_addr_t           bin
);
  import uvgh_pkg::*;

  logic [SIZE_W-1:0] cols;
  logic [SIZE_W-1:0] rows;
  logic [17:0]       x;
  logic [17:0]       y;
  logic              x_ok;
  logic              y_ok;
  logic [IDX_W-1:0]  col_pt;
  logic [IDX_W-1:0]  row_pt;
  logic [IDX_W-1:0]  col_sel;
  logic [IDX_W-1:0]  row_sel;
  logic              rd_ok;

  // Mirror (in 18 bits so that -1.0 becomes exactly +1.0), then add one half.
  function automatic logic [17:0] shift_coord(input logic [COORD_W-1:0] c,
                                              input logic flip);
    logic [17:0] ce;
    ce = {{2{c[COORD_W-1]}}, c};
    return (flip ? -ce : ce) + HALF_Q15;
  endfunction

  // floor(x * n / 2^15), clamped to the last bin.
  function automatic logic [IDX_W-1:0] to_bin(input logic [17:0] xv,
                                              input logic [SIZE_W-1:0] n);
    logic [COORD_W+SIZE_W-1:0] prod;
    logic [SIZE_W:0]           idx;
    logic [SIZE_W:0]           last;
    prod = xv[COORD_W-1:0] * n;
    idx  = (SIZE_W + 1)'(prod >> 15);
    last = (SIZE_W + 1)'(n) - (SIZE_W + 1)'(1);
    return IDX_W'((idx > last) ? last : idx);
  endfunction

  always_comb begin
    cols    = eff_size(grid_cols, MAX_COLS);
    rows    = eff_size(grid_rows, MAX_ROWS);
    x       = shift_coord(point_u, flip_u);
    y       = shift_coord(point_v, flip_v);
    x_ok    = !x[17] && (x <= ONE_Q15);
    y_ok    = !y[17] && (y <= ONE_Q15);
    col_pt  = to_bin(x, cols);
    row_pt  = to_bin(y, rows);
    rd_ok   = (IDX_W'(bin_col) < IDX_W'(cols)) && (IDX_W'(bin_row) < IDX_W'(rows));
    col_sel = is_read ? IDX_W'(bin_col) : col_pt;
    row_sel = is_read ? IDX_W'(bin_row) : row_pt;
    bin.hit  = is_read ? rd_ok : (x_ok && y_ok);
    bin.addr = ADDR_W'(32'(row_sel) * MAX_COLS + 32'(col_sel));
  end

endmodule

>>> sv/uvgh_alu.sv
// Shared subtract and compare unit used by every step of the divide and the root.
// Depends on uvgh_pkg.
module uvgh_alu (
  input  logic [uvgh_pkg::ALU_W-1:0] a,
  input  logic [uvgh_pkg::ALU_W-1:0] b,
  output uvgh_pkg::alu_res_t         res
);
  import uvgh_pkg::*;

  logic [ALU_W:0] d;

  always_comb begin
    d        = {1'b0, a} - {1'b0, b};
    res.ge   = !d[ALU_W];
    res.diff = d[ALU_W-1:0];
  end

endmodule

>>> bench/uv_grid_histogram_descriptor_top_test.sv
// Self-checking testbench for the uv grid histogram descriptor top level.
// Needs uvgh_pkg and the RTL of uv_grid_histogram_descriptor_top; reads no files.
// A directed table runs first, then random phases and short runs on a one-by-one and a two-column grid.
`timescale 1ns / 100ps

module uv_grid_histogram_descriptor_top_test;
  import uvgh_pkg::*;

  // No item may move for this many cycles before the run is declared hung. The longest
  // legal silence is a clear (its sweep of the store) plus a full sender gap and
  // receiver stall, or the sweep that follows reset; this is several times either.
  localparam int WATCHDOG_LIMIT = 20000;

  // Number of adds on the one-by-one grid, all of which land in the single bin.
  localparam int FILL_ADDS = 16;

  // Expected content of one result item.
  typedef struct packed {
    logic        hit;
    logic [15:0] count;
    logic [15:0] value;
    logic [15:0] total;
  } bin_report_t;

  // One row of the directed table: either a register write or a request item.
  typedef struct {
    bit          is_reg;
    logic [1:0]  reg_idx;
    logic [6:0]  reg_val;
    logic [1:0]  fn;
    logic [15:0] u;
    logic [15:0] v;
    logic [5:0]  col;
    logic [5:0]  row;
    bit          typed;
    bin_report_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // [15:0] point_u, [31:16] point_v, [37:32] bin_col, [43:38] bin_row, [47:44] zero
  logic [47:0] s_tdata;
  // [1:0] func
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  // [0] point_binned, [16:1] bin_count, [32:17] bin_value, [48:33] total_points,
  // [55:49] zero
  logic [55:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  // Shadow of the block: configuration, grid store and running total.
  logic [6:0]  cfg_cols;
  logic [6:0]  cfg_rows;
  logic        cfg_flip_u;
  logic        cfg_flip_v;
  logic [15:0] bin_store [DEPTH];
  logic [15:0] grid_total;
  logic [5:0]  last_col;
  logic [5:0]  last_row;

  bin_report_t pending_reports [$];
  dir_row_t    dir_table [$];

  // When set, neither side idles: used for stretches of full-rate traffic.
  bit no_idle;

  int fail_count;
  int requests_sent;
  int points_binned;
  int points_skipped;
  int reads_done;
  int reads_nonzero;
  int clears_done;
  int reg_writes;

  uv_grid_histogram_descriptor_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Grid size actually in use for a register value: zero acts as one, and anything above
  // the store's limit acts as the limit.
  function automatic int grid_extent(input logic [6:0] r, input int limit);
    if (r == 7'd0) begin
      return 1;
    end
    return (int'(r) > limit) ? limit : int'(r);
  endfunction

  // Mirror and shift one Q1.15 coordinate; -1 marks a point outside the unit square.
  // Negating -1.0 is done in int, so it becomes exactly +1.0 rather than wrapping.
  function automatic int half_shift(input logic [15:0] c, input logic flip);
    int s;
    int x;
    s = $signed(c);
    if (flip) begin
      s = -s;
    end
    x = s + 16384;
    return (x < 0 || x > 32768) ? -1 : x;
  endfunction

  // Bin of a shifted coordinate; exactly 1.0 lands one past the end and is pulled back.
  function automatic int to_cell(input int x, input int n);
    int idx;
    idx = (x * n) >>> 15;
    return (idx > n - 1) ? n - 1 : idx;
  endfunction

  // Floor square root, found one result bit at a time from the top.
  function automatic logic [63:0] floor_root(input logic [63:0] q);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 24; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) begin
        r = t;
      end
    end
    return r;
  endfunction

  // Apply one request to the shadow state and return the result item it should cause.
  function automatic bin_report_t predict_bin_report(input logic [1:0] fn,
                                                     input logic [15:0] u,
                                                     input logic [15:0] v,
                                                     input logic [5:0] col,
                                                     input logic [5:0] row);
    bin_report_t rep;
    int          ncols;
    int          nrows;
    int          x;
    int          y;
    int          c;
    int          r;
    logic [15:0] cnt;
    logic [63:0] quot;
    logic [63:0] root;
    rep = '0;
    ncols = grid_extent(cfg_cols, MAX_COLS);
    nrows = grid_extent(cfg_rows, MAX_ROWS);
    case (fn)
      FUNC_ADD: begin
        x = half_shift(u, cfg_flip_u);
        y = half_shift(v, cfg_flip_v);
        if (x >= 0 && y >= 0) begin
          c = to_cell(x, ncols);
          r = to_cell(y, nrows);
          if (bin_store[r * MAX_COLS + c] != 16'hFFFF) begin
            bin_store[r * MAX_COLS + c]++;
          end
          if (grid_total != 16'hFFFF) begin
            grid_total++;
          end
          rep.hit = 1'b1;
          last_col = 6'(c);
          last_row = 6'(r);
          points_binned++;
        end else begin
          points_skipped++;
        end
      end
      FUNC_READ: begin
        reads_done++;
        if (int'(col) < ncols && int'(row) < nrows) begin
          cnt = bin_store[int'(row) * MAX_COLS + int'(col)];
          rep.count = cnt;
          if (cnt != 16'd0) begin
            reads_nonzero++;
          end
          if (grid_total != 16'd0) begin
            quot = (64'(cnt) << 32) / 64'(grid_total);
            root = floor_root(quot);
            rep.value = (root > 64'd65535) ? 16'hFFFF : root[15:0];
          end
        end
      end
      FUNC_CLEAR: begin
        foreach (bin_store[i]) begin
          bin_store[i] = '0;
        end
        grid_total = '0;
        clears_done++;
      end
      default: begin
      end
    endcase
    rep.total = grid_total;
    return rep;
  endfunction

  function automatic void row_item(input logic [1:0] fn, input logic [15:0] u,
                                   input logic [15:0] v, input logic [5:0] col,
                                   input logic [5:0] row, input bit typed, input logic hit,
                                   input logic [15:0] cnt, input logic [15:0] val,
                                   input logic [15:0] tot);
    dir_row_t e;
    e = '{default: '0};
    e.fn = fn;
    e.u = u;
    e.v = v;
    e.col = col;
    e.row = row;
    e.typed = typed;
    e.want = {hit, cnt, val, tot};
    dir_table.insert(dir_table.size(), e);
  endfunction

  function automatic void row_reg(input logic [1:0] idx, input logic [6:0] val);
    dir_row_t e;
    e = '{default: '0};
    e.is_reg = 1'b1;
    e.reg_idx = idx;
    e.reg_val = val;
    dir_table.insert(dir_table.size(), e);
  endfunction

  // Mostly coordinates that land inside the unit square after the shift, with the edges of
  // that square, the extremes of Q1.15 and some fully random values mixed in.
  function automatic logic [15:0] pick_coord();
    int t;
    case ($urandom_range(0, 11))
      0: t = $urandom;
      1: t = -32768;
      2: t = 32767;
      3: t = -16384;
      4: t = 16384;
      5: t = ($urandom_range(0, 1) != 0) ? 16385 : -16385;
      default: t = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return 16'(t);
  endfunction

  // Grid size for a phase: the out-of-range values, the limits, and plenty of small grids
  // so that bins fill up enough for the read path to see real ratios.
  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd127;
      4, 5: return 7'($urandom_range(2, 8));
      6: return 7'($urandom_range(9, 63));
      default: return 7'($urandom_range(65, 126));
    endcase
  endfunction

  // Present one request item and hold it until it is taken. The sender's gap is drawn on
  // entry; s_tvalid is left high on return, so a following item with no gap keeps it high.
  task automatic send_request(input logic [1:0] fn, input logic [15:0] u,
                              input logic [15:0] v, input logic [5:0] col,
                              input logic [5:0] row, input bit typed,
                              input bin_report_t want);
    int          gap;
    bin_report_t model_rep;
    @(negedge clk);
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= {4'b0000, row, col, v, u};
    do @(posedge clk); while (!s_tready);
    model_rep = predict_bin_report(fn, u, v, col, row);
    pending_reports.insert(pending_reports.size(), typed ? want : model_rep);
    requests_sent++;
  endtask

  // Stop offering items and wait until every pending result has been taken.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Registers change only with the block idle. Every item causes a result, so once the
  // last one is out the sequencer is free; a few cycles more cover the output register.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRID_COLS: cfg_cols = val;
      REG_GRID_ROWS: cfg_rows = val;
      REG_FLIP_U:    cfg_flip_u = val[0];
      default:       cfg_flip_v = val[0];
    endcase
    reg_writes++;
  endtask

  task automatic random_request();
    int          pick;
    logic [1:0]  fn;
    logic [15:0] u;
    logic [15:0] v;
    logic [5:0]  c;
    logic [5:0]  r;
    pick = $urandom_range(0, 999);
    u = 16'($urandom);
    v = 16'($urandom);
    c = 6'($urandom);
    r = 6'($urandom);
    if (pick < 620) begin
      fn = FUNC_ADD;
      // Roughly one add in ten keeps fully random coordinates as noise.
      if (pick >= 60) begin
        u = pick_coord();
        v = pick_coord();
      end
    end else if (pick < 940) begin
      fn = FUNC_READ;
      case ($urandom_range(0, 9))
        0, 1: begin
        end
        2, 3, 4: begin
          c = 6'($urandom_range(0, grid_extent(cfg_cols, MAX_COLS) - 1));
          r = 6'($urandom_range(0, grid_extent(cfg_rows, MAX_ROWS) - 1));
        end
        default: begin
          // Reading the bin that last took a point gives non-zero counts most of the time.
          c = last_col;
          r = last_row;
        end
      endcase
    end else if (pick < 990) begin
      fn = FUNC_NOP;
    end else begin
      fn = FUNC_CLEAR;
    end
    send_request(fn, u, v, c, r, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (want !== seen) begin
      fail_count++;
      if (fail_count <= 40) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
      end
    end
  endtask

  // Receiver: draws a stall per item, then takes the result and checks it against the
  // oldest pending expectation.
  initial begin
    bin_report_t seen;
    bin_report_t due;
    int          stall;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      seen = {m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tdata[48:33]};
      if (pending_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= 40) begin
          $display("%0t: result with nothing pending, expected none, got %h", $time, seen);
        end
      end else begin
        due = pending_reports.pop_front();
        check_field("point_binned", 16'(due.hit), 16'(seen.hit));
        check_field("bin_count", due.count, seen.count);
        check_field("bin_value", due.value, seen.value);
        check_field("total_points", due.total, seen.total);
      end
      @(negedge clk);
    end
  end

  // Watchdog: ends the run if no item moves on either side for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no item moved for %0d cycles, %0d results still pending", $time,
             WATCHDOG_LIMIT, pending_reports.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int pause_at;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = FUNC_NOP;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_GRID_COLS;
    cfg_data  = '0;
    cfg_cols   = 7'd48;
    cfg_rows   = 7'd48;
    cfg_flip_u = 1'b0;
    cfg_flip_v = 1'b0;
    foreach (bin_store[i]) begin
      bin_store[i] = '0;
    end
    grid_total = '0;
    last_col   = '0;
    last_row   = '0;
    no_idle    = 1'b0;

    // Directed table. Under the reset grid of 48 by 48: reads of an empty store, a point at
    // the centre, both corners of the square, points just outside it and a clear.
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd0,  6'd0,  1, 0, 0, 0, 0);
    row_item(FUNC_NOP,   16'h0000, 16'h0000, 6'd0,  6'd0,  1, 0, 0, 0, 0);
    row_item(FUNC_ADD,   16'h0000, 16'h0000, 6'd0,  6'd0,  1, 1, 0, 0, 1);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd24, 6'd24, 1, 0, 1, 16'hFFFF, 1);
    row_item(FUNC_ADD,   16'hC000, 16'hC000, 6'd63, 6'd63, 1, 1, 0, 0, 2);
    row_item(FUNC_ADD,   16'h4000, 16'h4000, 6'd0,  6'd0,  1, 1, 0, 0, 3);
    row_item(FUNC_ADD,   16'hBFFF, 16'h0000, 6'd0,  6'd0,  1, 0, 0, 0, 3);
    row_item(FUNC_ADD,   16'h0000, 16'h4001, 6'd0,  6'd0,  1, 0, 0, 0, 3);
    row_item(FUNC_ADD,   16'h7FFF, 16'h8000, 6'd0,  6'd0,  1, 0, 0, 0, 3);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd47, 6'd47, 0, 0, 0, 0, 0);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd48, 6'd0,  1, 0, 0, 0, 3);
    row_item(FUNC_READ,  16'hFFFF, 16'hFFFF, 6'd63, 6'd63, 1, 0, 0, 0, 3);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd0,  6'd0,  0, 0, 0, 0, 0);
    row_item(FUNC_CLEAR, 16'h0000, 16'h0000, 6'd0,  6'd0,  1, 0, 0, 0, 0);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd24, 6'd24, 1, 0, 0, 0, 0);
    // A zero column count acts as one, both axes mirrored; mirroring -1.0 gives +1.0,
    // which the shift then pushes outside the square.
    row_reg(REG_GRID_COLS, 7'd0);
    row_reg(REG_GRID_ROWS, 7'd64);
    row_reg(REG_FLIP_U, 7'd1);
    row_reg(REG_FLIP_V, 7'd1);
    row_item(FUNC_ADD,   16'h8000, 16'h0000, 6'd0,  6'd0,  1, 0, 0, 0, 0);
    row_item(FUNC_ADD,   16'h4000, 16'hC000, 6'd0,  6'd0,  1, 1, 0, 0, 1);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd0,  6'd63, 1, 0, 1, 16'hFFFF, 1);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd1,  6'd0,  1, 0, 0, 0, 1);
    // Sizes above the limit act as the limit and zero rows as one; the stored count stays
    // where it was and shows up again once the rows cover it.
    row_reg(REG_GRID_COLS, 7'd127);
    row_reg(REG_GRID_ROWS, 7'd0);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd0,  6'd63, 1, 0, 0, 0, 1);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd0,  6'd0,  1, 0, 0, 0, 1);
    row_reg(REG_GRID_ROWS, 7'd127);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd0,  6'd63, 1, 0, 1, 16'hFFFF, 1);
    row_item(FUNC_ADD,   16'hC000, 16'h4000, 6'd0,  6'd0,  1, 1, 0, 0, 2);
    row_item(FUNC_READ,  16'h0000, 16'h0000, 6'd63, 6'd0,  0, 0, 0, 0, 0);
    row_item(FUNC_NOP,   16'hFFFF, 16'hFFFF, 6'd63, 6'd63, 1, 0, 0, 0, 2);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      if (dir_table[i].is_reg) begin
        write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
      end else begin
        send_request(dir_table[i].fn, dir_table[i].u, dir_table[i].v, dir_table[i].col,
                     dir_table[i].row, dir_table[i].typed, dir_table[i].want);
      end
    end

    // Random phases, each under a fresh setting and with only the random clears in between, so counts
    // left by one grid size are read back under the next. Every fourth phase runs at full
    // rate on both sides; each phase also has one point where the sender waits for all
    // pending results before going on.
    for (int phase = 0; phase < 12; phase++) begin
      no_idle = 1'b0;
      write_reg(REG_GRID_COLS, pick_size());
      write_reg(REG_GRID_ROWS, pick_size());
      write_reg(REG_FLIP_U, 7'($urandom_range(0, 127)));
      write_reg(REG_FLIP_V, 7'($urandom_range(0, 127)));
      no_idle = (phase % 4 == 3);
      pause_at = $urandom_range(10, 150);
      for (int i = 0; i < 160; i++) begin
        if (i == pause_at) begin
          drain_results();
        end
        random_request();
      end
    end

    // One-by-one grid: every point inside the square lands in the same bin, so after a
    // clear that bin holds the whole total and its value is the saturated ratio of one.
    no_idle = 1'b0;
    write_reg(REG_GRID_COLS, 7'd1);
    write_reg(REG_GRID_ROWS, 7'd1);
    write_reg(REG_FLIP_U, 7'($urandom_range(0, 127)));
    write_reg(REG_FLIP_V, 7'($urandom_range(0, 127)));
    send_request(FUNC_CLEAR, 16'($urandom), 16'($urandom), 6'($urandom), 6'($urandom),
                 1'b0, '0);
    no_idle = 1'b1;
    repeat (FILL_ADDS) begin
      send_request(FUNC_ADD, 16'($urandom_range(0, 32768) - 16384),
                   16'($urandom_range(0, 32768) - 16384), 6'($urandom), 6'($urandom),
                   1'b0, '0);
    end
    no_idle = 1'b0;
    send_request(FUNC_READ, 16'($urandom), 16'($urandom), 6'd0, 6'd0, 1'b1,
                 {1'b0, 16'(FILL_ADDS), 16'hFFFF, 16'(FILL_ADDS)});
    // A second column next to the full bin: the ratio of each bin can now fall below one.
    write_reg(REG_GRID_COLS, 7'd2);
    repeat (16) begin
      random_request();
    end
    send_request(FUNC_READ, 16'($urandom), 16'($urandom), 6'd1, 6'd0, 1'b0, '0);
    send_request(FUNC_READ, 16'($urandom), 16'($urandom), 6'd0, 6'd0, 1'b0, '0);

    // A clear is the slowest item; the drain and the wait after it let any stray item show.
    drain_results();
    repeat (100) @(posedge clk);

    $display("Ran %0d requests: %0d points binned, %0d skipped, %0d reads (%0d non-zero).",
             requests_sent, points_binned, points_skipped, reads_done, reads_nonzero);
    $display("%0d clears and %0d register writes across grids of every size and mirror.",
             clears_done, reg_writes);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d checks failed", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
